// ===== design/ebpr_pkg.sv =====
// Package with shared types, constants and the arctangent table of the rotator.
`default_nettype none
package ebpr_pkg;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned PhaseWidth = 32;
  localparam int unsigned GainQ20 = 636751;
  // Largest number of spectral points a data set is expected to carry.
  localparam int unsigned SpecMax = 2048;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoConfig = 2'd1,
    StatusKRange   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RegNumKRead    = 2'd0,
    RegEncodeAxis  = 2'd1,
    RegKOriginX2   = 2'd2,
    RegNumSpecPts  = 2'd3
  } reg_index_e;

  function automatic logic [PhaseWidth-1:0] atan_turns(input logic [3:0] idx);
    logic [PhaseWidth-1:0] v;
    unique case (idx)
      4'd0:  v = 32'h20000000;
      4'd1:  v = 32'h12E4051E;
      4'd2:  v = 32'h09FB385B;
      4'd3:  v = 32'h051111D4;
      4'd4:  v = 32'h028B0D43;
      4'd5:  v = 32'h0145D7E1;
      4'd6:  v = 32'h00A2F61E;
      4'd7:  v = 32'h00517C55;
      4'd8:  v = 32'h0028BE53;
      4'd9:  v = 32'h00145F2F;
      4'd10: v = 32'h000A2F98;
      4'd11: v = 32'h000517CC;
      4'd12: v = 32'h00028BE6;
      4'd13: v = 32'h000145F3;
      4'd14: v = 32'h0000A2FA;
      default: v = 32'h0000517D;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== design/ebpr_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per cycle while en_i is high and hands it on.
`default_nettype none
module ebpr_div_cell #(
  parameter int unsigned RemW = 22,
  parameter int unsigned NumW = 52,
  parameter int unsigned QW   = 32,
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [RemW-1:0] rem_i,
  input  wire logic [RemW-1:0] den_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [QW-1:0]   quo_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic [RemW-1:0]      rem_o,
  output logic [RemW-1:0]      den_o,
  output logic [NumW-1:0]      num_o,
  output logic [QW-1:0]        quo_o,
  output logic [TagW-1:0]      tag_o
);
  logic [RemW:0] trial;
  logic [RemW:0] shifted;
  logic          fits;
  logic [RemW-1:0] rem_d;

  always_comb begin
    shifted = {rem_i, num_i[NumW-1]};
    trial   = shifted - {1'b0, den_i};
    fits    = !trial[RemW];
    rem_d   = fits ? trial[RemW-1:0] : shifted[RemW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // The quotient register keeps only its low QW bits as bits shift out the top.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      den_o <= den_i;
      num_o <= {num_i[NumW-2:0], 1'b0};
      quo_o <= {quo_i[QW-2:0], fits};
      tag_o <= tag_i;
    end
  end
endmodule
`default_nettype wire

// ===== design/ebpr_cordic_cell.sv =====
// One CORDIC micro-rotation cell with a fixed shift and arctangent constant.
`default_nettype none
module ebpr_cordic_cell #(
  parameter int unsigned XW    = 28,
  parameter int unsigned Shift = 0,
  parameter int unsigned TagW  = 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic signed [XW-1:0]   x_i,
  input  wire logic signed [XW-1:0]   y_i,
  input  wire logic signed [31:0]     z_i,
  input  wire logic [TagW-1:0]        tag_i,
  output logic                        valid_o,
  output logic signed [XW-1:0]        x_o,
  output logic signed [XW-1:0]        y_o,
  output logic signed [31:0]          z_o,
  output logic [TagW-1:0]             tag_o
);
  import ebpr_pkg::*;
  localparam logic [31:0] Atan = atan_turns(4'(Shift));
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    xs = x_i >>> Shift;
    ys = y_i >>> Shift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_o <= tag_i;
      if (!z_i[31]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - $signed(Atan);
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + $signed(Atan);
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/epsi_bilinear_phase_rotator_top.sv =====
// Top level of the linear phase rotator: phase setup, divider and CORDIC cell chains.
//
// Usage: each transaction on the s_axis channel carries one complex spectral sample with
// its voxel coordinates and frequency index. The m_axis channel returns one transaction
// per input in order: the rotated sample and a status code. The sample is multiplied by
// exp(-i*2*pi*(k-k0)(f-M/2)/(2NM)).
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_data_i while idle.
// The pipeline is a row of cells: two setup stages, one restoring-division cell per
// dividend bit (52 cells), a quadrant stage, 16 CORDIC cells and a gain stage, then the
// output register that rounds and saturates. Throughput is one transaction per cycle
// while the receiver takes results, since every cell then takes a new item each cycle.
// Reset empties every stage (all valid bits clear). When the receiver stalls the whole
// pipeline holds: every cell advances only while the output register is free or
// being taken, so s_axis_tready follows that condition.
`default_nettype none
module epsi_bilinear_phase_rotator_top #(
  parameter int unsigned K_MAX        = 256,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: coord_x[7:0], coord_y[15:8], coord_z[23:16], freq_index[34:24],
  // sample_re, sample_im, zero fill to bytes
  input  wire logic [((35+2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: rotated_re, rotated_im, status (2 bits), zero fill to bytes
  output logic [((2*SAMPLE_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [11:0] cfg_data_i
);
  import ebpr_pkg::*;
  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned OutW = ((2*SW+2+7)/8)*8;
  localparam int unsigned XW   = SW + 12;
  // |num| < 2^22 and D = N*M < 2^21: dividend |num|*2^30 + D < 2^52, divisor 2D < 2^22.
  localparam int unsigned RemW = 22;
  localparam int unsigned NumW = 52;
  localparam int unsigned QW   = 32;
  localparam int unsigned NDiv = NumW;
  localparam int unsigned TagW = 2*SW + 3;

  // Pipeline enable: everything moves when the output register can take data.
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic [8:0]  nkr_q;
  logic [2:0]  axis_q;
  logic [10:0] ko2_q;
  logic [11:0] nsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nkr_q  <= '0;
      axis_q <= 3'b111;
      ko2_q  <= 11'h7FF;
      nsp_q  <= 12'd2048;
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_addr_i))
        RegNumKRead:   nkr_q  <= cfg_data_i[8:0];
        RegEncodeAxis: axis_q <= cfg_data_i[2:0];
        RegKOriginX2:  ko2_q  <= cfg_data_i[10:0];
        default:       nsp_q  <= cfg_data_i[11:0];
      endcase
    end
  end

  // Stage 1: select k, classify, form the factors.
  logic [7:0]  k_sel;
  logic        bad_cfg, bad_k;
  logic        in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (axis_q)
      3'd0:    k_sel = s_axis_tdata[7:0];
      3'd1:    k_sel = s_axis_tdata[15:8];
      default: k_sel = s_axis_tdata[23:16];
    endcase
    bad_cfg = (nkr_q == '0) || (nsp_q == '0) || axis_q[2] || (axis_q == 3'd3);
    bad_k   = ({1'b0, k_sel} >= nkr_q) || (32'(k_sel) >= K_MAX);
  end

  logic               s1_v_q;
  logic signed [11:0] s1_a_q;   // 2k - ko2, or 2k - N if ko2[10] is set
  logic signed [12:0] s1_b_q;   // 2f - M
  logic [20:0]        s1_den_q; // N*M
  logic [1:0]         s1_st_q;
  logic [2*SW-1:0]    s1_smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (adv) s1_v_q <= in_fire;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q   <= $signed({3'b0, k_sel, 1'b0}) -
                  (ko2_q[10] ? $signed({3'b0, nkr_q}) : $signed({1'b0, ko2_q}));
      s1_b_q   <= $signed({1'b0, s_axis_tdata[34:24], 1'b0}) - $signed({1'b0, nsp_q});
      s1_den_q <= {12'b0, nkr_q} * {9'b0, nsp_q};
      s1_st_q  <= bad_cfg ? StatusNoConfig : (bad_k ? StatusKRange : StatusOk);
      s1_smp_q <= s_axis_tdata[35 +: 2*SW];
    end
  end

  // Stage 2: product magnitude and sign. Rounding |num|*2^32/(8NM) to nearest is the
  // quotient of (|num|*2^30 + NM) by 2NM.
  logic signed [24:0] prod;
  logic [21:0]        mag;
  assign prod = s1_a_q * s1_b_q;
  assign mag  = 22'(prod[24] ? -prod : prod);

  logic            s2_v_q;
  logic [NumW-1:0] s2_num_q;
  logic [RemW-1:0] s2_div_q;
  logic [TagW-1:0] s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_num_q <= {mag, 30'b0} + {31'b0, s1_den_q};
      s2_div_q <= {s1_den_q, 1'b0};
      s2_tag_q <= {prod[24], s1_st_q, s1_smp_q};
    end
  end

  // Division chain: one cell per dividend bit, most significant bit first. Only the
  // low 32 quotient bits are kept, which is the phase modulo one turn.
  logic            dv_v   [NDiv+1];
  logic [RemW-1:0] dv_rem [NDiv+1];
  logic [RemW-1:0] dv_den [NDiv+1];
  logic [NumW-1:0] dv_num [NDiv+1];
  logic [QW-1:0]   dv_quo [NDiv+1];
  logic [TagW-1:0] dv_tag [NDiv+1];

  assign dv_v[0]   = s2_v_q;
  assign dv_rem[0] = '0;
  assign dv_den[0] = s2_div_q;
  assign dv_num[0] = s2_num_q;
  assign dv_quo[0] = '0;
  assign dv_tag[0] = s2_tag_q;

  for (genvar g = 0; g < NDiv; g++) begin : g_div
    ebpr_div_cell #(.RemW(RemW), .NumW(NumW), .QW(QW), .TagW(TagW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_v[g]),
      .rem_i   (dv_rem[g]),
      .den_i   (dv_den[g]),
      .num_i   (dv_num[g]),
      .quo_i   (dv_quo[g]),
      .tag_i   (dv_tag[g]),
      .valid_o (dv_v[g+1]),
      .rem_o   (dv_rem[g+1]),
      .den_o   (dv_den[g+1]),
      .num_o   (dv_num[g+1]),
      .quo_o   (dv_quo[g+1]),
      .tag_o   (dv_tag[g+1])
    );
  end

  // Quadrant stage.
  logic signed [31:0] zq;
  logic signed [SW-1:0] sre, sim;
  logic signed [XW-1:0] x0, y0;
  assign zq  = dv_tag[NDiv][TagW-1] ? $signed(dv_quo[NDiv]) : $signed(32'd0 - dv_quo[NDiv]);
  assign sre = dv_tag[NDiv][SW-1:0];
  assign sim = dv_tag[NDiv][2*SW-1:SW];
  assign x0  = XW'(sre) <<< 8;
  assign y0  = XW'(sim) <<< 8;

  logic                cv   [CordicStages+1];
  logic signed [XW-1:0] cx  [CordicStages+1];
  logic signed [XW-1:0] cy  [CordicStages+1];
  logic signed [31:0]  cz   [CordicStages+1];
  logic [1:0]          ct   [CordicStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv[0] <= 1'b0;
    else if (adv) cv[0] <= dv_v[NDiv];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ct[0] <= dv_tag[NDiv][2*SW +: 2];
      if (zq > 32'sh40000000) begin
        cx[0] <= -y0; cy[0] <= x0; cz[0] <= zq - 32'sh40000000;
      end else if (zq < -32'sh40000000) begin
        cx[0] <= y0; cy[0] <= -x0; cz[0] <= zq + 32'sh40000000;
      end else begin
        cx[0] <= x0; cy[0] <= y0; cz[0] <= zq;
      end
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
    ebpr_cordic_cell #(.XW(XW), .Shift(g), .TagW(2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cv[g]),
      .x_i     (cx[g]),
      .y_i     (cy[g]),
      .z_i     (cz[g]),
      .tag_i   (ct[g]),
      .valid_o (cv[g+1]),
      .x_o     (cx[g+1]),
      .y_o     (cy[g+1]),
      .z_o     (cz[g+1]),
      .tag_o   (ct[g+1])
    );
  end

  // Gain stage then round and saturate into the output register.
  logic                g_v_q;
  logic signed [XW+20:0] gx_q, gy_q;
  logic [1:0]          g_st_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_v_q <= 1'b0;
    else if (adv) g_v_q <= cv[CordicStages];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      gx_q   <= cx[CordicStages] * $signed(21'(GainQ20));
      gy_q   <= cy[CordicStages] * $signed(21'(GainQ20));
      g_st_q <= ct[CordicStages];
    end
  end

  function automatic logic [SW-1:0] rnd_sat(input logic signed [XW+20:0] v);
    logic signed [XW+20:0] r;
    logic signed [XW-8:0]  s;
    r = (v + $signed((XW+21)'(1) <<< 27)) >>> 28;
    s = r[XW-8:0];
    if (s > $signed((XW-7)'((1 << (SW-1)) - 1))) return {1'b0, {(SW-1){1'b1}}};
    if (s < -$signed((XW-7)'(1 << (SW-1)))) return {1'b1, {(SW-1){1'b0}}};
    return s[SW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= g_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (g_st_q == StatusOk)
        m_axis_tdata <= OutW'({g_st_q, rnd_sat(gy_q), rnd_sat(gx_q)});
      else
        m_axis_tdata <= OutW'({g_st_q, {(2*SW){1'b0}}});
    end
  end
endmodule
`default_nettype wire

// ===== design/ebpr_checker.sv =====
// Port-level checker for the phase rotator, bound to the top level.
`default_nettype none
module ebpr_checker #(
  parameter int unsigned SW = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [((2*SW+2+7)/8)*8-1:0] m_axis_tdata
);
  import ebpr_pkg::*;

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with free output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2*SW +: 2] <= StatusKRange) else $error("bad status");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2*SW +: 2] != StatusOk |-> m_axis_tdata[2*SW-1:0] == '0)
    else $error("error result with nonzero data");
endmodule

bind epsi_bilinear_phase_rotator_top ebpr_checker #(.SW(SAMPLE_WIDTH)) u_ebpr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench of the linear phase rotator: directed table plus random streams, checked in order.
`timescale 1ns / 1ps
module tb;
  import ebpr_pkg::*;

  localparam int unsigned SW = 16;
  localparam int unsigned InW = 72;
  localparam int unsigned OutW = 40;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainCycles = 70;
  localparam int unsigned NumPhases = 7;
  localparam int unsigned PhaseItems = 200;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam longint ArcTab [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct packed {
    logic [7:0]           cx;
    logic [7:0]           cy;
    logic [7:0]           cz;
    logic [10:0]          freq;
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
  } sample_t;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    status_e              st;
  } rotated_t;

  typedef struct {
    bit         is_cfg;
    reg_index_e idx;
    logic [11:0] val;
    sample_t    smp;
    bit         typed;
    rotated_t   res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [11:0] cfg_data_i = '0;

  // Shadow copies of the configuration registers.
  logic [8:0]         n_reg;
  logic signed [2:0]  axis_reg;
  logic signed [10:0] ko2_reg;
  logic [11:0]        m_reg;

  rotated_t rotated_q [$];
  row_t     dir_tab [$];
  int       mismatches = 0;
  int       stall_cnt = 0;
  bit       calm = 1'b0;

  epsi_bilinear_phase_rotator_top i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_addr_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [SW-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[SW-1:0];
  endfunction

  function automatic rotated_t rotate_sample(sample_t s);
    rotated_t r;
    longint n, m, ax, ko2, k, f, num, den, z, x, y, t;
    longint unsigned mag, q, ang;
    n = n_reg;
    m = m_reg;
    ax = axis_reg;
    ko2 = ko2_reg;
    r = '{re: '0, im: '0, st: StatusOk};
    if (n == 0 || m == 0 || ax < 0 || ax > 2) begin
      r.st = StatusNoConfig;
      return r;
    end
    k = (ax == 0) ? s.cx : (ax == 1) ? s.cy : s.cz;
    if (k >= n || k >= 256) begin
      r.st = StatusKRange;
      return r;
    end
    f = s.freq;
    if (ko2 < 0) ko2 = n;
    num = (2 * k - ko2) * (2 * f - m);
    den = 8 * n * m;
    mag = (num < 0) ? -num : num;
    q = ((mag << 33) + den) / (2 * den);
    q &= 64'hFFFF_FFFF;
    ang = (num < 0) ? q : ((64'h1_0000_0000 - q) & 64'hFFFF_FFFF);
    z = (ang >= 64'h8000_0000) ? longint'(ang) - 64'h1_0000_0000 : longint'(ang);
    x = longint'(s.re) * 256;
    y = longint'(s.im) * 256;
    // Quadrant pre-rotation keeps the CORDIC within its convergence range.
    if (z > 64'sh4000_0000) begin
      t = x; x = -y; y = t;
      z -= 64'sh4000_0000;
    end else if (z < -64'sh4000_0000) begin
      t = x; x = y; y = -t;
      z += 64'sh4000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      longint xs, ys;
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ArcTab[i];
      end else begin
        x += ys; y -= xs; z += ArcTab[i];
      end
    end
    r.re = clamp16((x * 636751 + (64'sd1 <<< 27)) >>> 28);
    r.im = clamp16((y * 636751 + (64'sd1 <<< 27)) >>> 28);
    return r;
  endfunction

  task automatic write_reg(reg_index_e idx, logic [11:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      RegNumKRead:   n_reg = v[8:0];
      RegEncodeAxis: axis_reg = v[2:0];
      RegKOriginX2:  ko2_reg = v[10:0];
      default:       m_reg = v;
    endcase
  endtask

  task automatic drain();
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send(sample_t s, bit typed, rotated_t res);
    while (!calm && $urandom_range(99) < 32) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata = {5'b0, s.im, s.re, s.freq, s.cz, s.cy, s.cx};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    rotated_q.push_back(typed ? res : rotate_sample(s));
    @(negedge clk_i);
  endtask

  function automatic row_t cfg_row(reg_index_e idx, logic [11:0] v);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = v;
    r.smp = '0;
    r.typed = 1'b0;
    r.res = '{re: '0, im: '0, st: StatusOk};
    return r;
  endfunction

  function automatic row_t smp_row(int x, int y, int z, int f, int re, int im,
                                   bit typed = 0, status_e st = StatusOk);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx = RegNumKRead;
    r.val = '0;
    r.smp = '{cx: 8'(x), cy: 8'(y), cz: 8'(z), freq: 11'(f), re: 16'(re), im: 16'(im)};
    r.typed = typed;
    r.res = '{re: '0, im: '0, st: st};
    return r;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int n;
    s = 67'({$urandom, $urandom, $urandom});
    n = n_reg;
    // Mostly keep the selected coordinate inside the lobe so the rotation path is exercised.
    if (n >= 1 && n <= 256 && $urandom_range(99) < 85) begin
      case (axis_reg)
        3'sd0: s.cx = 8'($urandom_range(n - 1));
        3'sd1: s.cy = 8'($urandom_range(n - 1));
        3'sd2: s.cz = 8'($urandom_range(n - 1));
        default: ;
      endcase
    end
    return s;
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    rotated_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got.re = m_axis_tdata[15:0];
        got.im = m_axis_tdata[31:16];
        got.st = status_e'(m_axis_tdata[33:32]);
        if (rotated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result re=%0d im=%0d st=%0d",
                                         got.re, got.im, got.st);
        end else begin
          want = rotated_q.pop_front();
          if (got.re !== want.re || got.im !== want.im || got.st !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                       want.re, want.im, want.st, got.re, got.im, got.st);
          end
        end
      end
      if (stall_cnt >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rotated_t none;
    none = '{re: '0, im: '0, st: StatusOk};
    n_reg = '0;
    axis_reg = -3'sd1;
    ko2_reg = -11'sd1;
    m_reg = 12'd2048;

    // After reset nothing is configured.
    dir_tab.push_back(smp_row(0, 0, 0, 0, 32767, -32768, 1, StatusNoConfig));
    dir_tab.push_back(smp_row(255, 255, 255, 2047, -32768, 32767, 1, StatusNoConfig));
    dir_tab.push_back(cfg_row(RegNumKRead, 12'd256));
    dir_tab.push_back(smp_row(0, 0, 0, 0, 100, 100, 1, StatusNoConfig));
    dir_tab.push_back(cfg_row(RegEncodeAxis, 12'd0));
    dir_tab.push_back(smp_row(0, 255, 255, 0, 32767, 32767));
    dir_tab.push_back(smp_row(255, 0, 0, 2047, -32768, -32768));
    dir_tab.push_back(smp_row(128, 3, 9, 1024, 12345, -54));
    dir_tab.push_back(smp_row(17, 0, 0, 1500, -32768, 32767));
    dir_tab.push_back(cfg_row(RegKOriginX2, 12'd512));
    dir_tab.push_back(cfg_row(RegNumSpecPts, 12'd1));
    dir_tab.push_back(smp_row(0, 0, 0, 2047, 32767, 0));
    dir_tab.push_back(smp_row(200, 0, 0, 0, 0, -32768));
    dir_tab.push_back(cfg_row(RegNumSpecPts, 12'd0));
    dir_tab.push_back(smp_row(5, 5, 5, 5, 5, 5, 1, StatusNoConfig));
    dir_tab.push_back(cfg_row(RegNumSpecPts, 12'd2048));
    dir_tab.push_back(cfg_row(RegNumKRead, 12'd100));
    dir_tab.push_back(cfg_row(RegEncodeAxis, 12'd1));
    dir_tab.push_back(smp_row(0, 100, 0, 10, 1, 1, 1, StatusKRange));
    dir_tab.push_back(smp_row(0, 99, 0, 10, -1, 1));
    dir_tab.push_back(cfg_row(RegEncodeAxis, 12'd2));
    dir_tab.push_back(smp_row(0, 0, 255, 10, 1, 1, 1, StatusKRange));
    dir_tab.push_back(smp_row(255, 255, 0, 300, 20000, -20000));
    dir_tab.push_back(cfg_row(RegEncodeAxis, 12'd3));
    dir_tab.push_back(smp_row(1, 1, 1, 1, 1, 1, 1, StatusNoConfig));
    dir_tab.push_back(cfg_row(RegEncodeAxis, 12'hFFF));
    dir_tab.push_back(smp_row(1, 1, 1, 1, 1, 1, 1, StatusNoConfig));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        s_axis_tvalid = 1'b0;
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      logic [11:0] nv, av, kv, mv;
      s_axis_tvalid = 1'b0;
      drain();
      if (ph == 0) begin
        nv = 12'd256; av = 12'd2; kv = 12'd512; mv = 12'd2048;
      end else if (ph == 1) begin
        nv = 12'd1; av = 12'd0; kv = 12'hFFF; mv = 12'd1;
      end else begin
        nv = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(1, 256));
        av = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(2));
        case ($urandom_range(9))
          0, 1, 2: kv = 12'hFFF;
          3:       kv = 12'($urandom);
          default: kv = 12'($urandom_range(512));
        endcase
        mv = ($urandom_range(19) == 0) ? 12'($urandom) : 12'($urandom_range(1, 2048));
      end
      write_reg(RegNumKRead, nv);
      write_reg(RegEncodeAxis, av);
      write_reg(RegKOriginX2, kv);
      write_reg(RegNumSpecPts, mv);
      calm = (ph == 3);
      for (int j = 0; j < PhaseItems; j++) send(rand_sample(), 1'b0, none);
      calm = 1'b0;
    end

    s_axis_tvalid = 1'b0;
    drain();
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
